// ===== design/rqs_pkg.sv =====
// ----------------------------------------------------------------------------
// rqs_pkg: shared definitions for the retry queue sender
// Queue sizing, operation and link codes, register map, controller states and
// the command group passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package rqs_pkg;

	// Ring queue sizing. The queue holds one byte fewer than its depth.
	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = IDX_W + 1;

	// Attempt counter.
	localparam int ATT_W = 9;
	localparam logic [ATT_W-1:0] ATT_SAT = '1;

	// Configuration port.
	localparam int ADDR_W = 3;
	localparam logic REG_ATTEMPT_LIMIT = 1'b0;
	localparam logic REG_NULL_CODE     = 1'b1;
	localparam logic [7:0] ATTEMPT_LIMIT_RST = 8'd3;
	localparam logic [7:0] NULL_CODE_RST     = 8'd0;

	// Operation codes.
	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_RETRY   = 1'b1;

	// Link outcome codes.
	localparam logic [1:0] LINK_PENDING = 2'd0;
	localparam logic [1:0] LINK_SUCCESS = 2'd1;
	localparam logic [1:0] LINK_ERROR   = 2'd2;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;   // latch the accepted transaction and read the queue head
		logic execute;   // apply the transaction and load the result register
	} ctrl_cmd_t;

endpackage

// ===== design/rqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// rqs_ctrl: transaction sequencer of the retry queue sender
// Accepts one input transaction, lets the datapath apply it once the result
// register is free, and owns the result valid flag.
// ----------------------------------------------------------------------------
module rqs_ctrl
	import rqs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	output logic      res_valid,
	input  logic      res_ready,
	output ctrl_cmd_t cmd
);

	state_t state_q, state_d;
	logic   res_valid_q;

	// State register and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.execute) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands.
	always_comb begin
		state_d     = state_q;
		item_ready  = 1'b0;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// The result register must be empty or emptying this cycle.
				if (!res_valid_q || res_ready) begin
					cmd.execute = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign res_valid = res_valid_q;

endmodule

// ===== design/rqs_datapath.sv =====
// ----------------------------------------------------------------------------
// rqs_datapath: queue, retry state and configuration of the retry queue sender
// Holds the ring queue memory, its indexes, the held message with its attempt
// count, the configuration registers and the result register.
// ----------------------------------------------------------------------------
module rqs_datapath
	import rqs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_cmd_t         cmd,
	input  logic              op,
	input  logic [7:0]        message_byte,
	input  logic [1:0]        link_result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic [1:0]        send_count,
	output logic [7:0]        send_byte,
	output logic              dropped,
	output logic              gave_up,
	output logic              busy_res,
	output logic [3:0]        queue_count
);

	// Ring queue memory and registered head read.
	logic [7:0] mem_q [QUEUE_DEPTH];
	logic [7:0] head_q;

	// Queue and retry state.
	logic [IDX_W-1:0] wr_idx_q, rd_idx_q;
	logic [7:0]       cur_byte_q;
	logic             cur_valid_q;
	logic [ATT_W-1:0] attempt_q;

	// Configuration registers.
	logic [7:0] attempt_limit_q, null_code_q;

	// Latched transaction.
	logic       op_q;
	logic [7:0] msg_q;
	logic [1:0] link_q;

	// Result register.
	logic [1:0] send_count_q;
	logic [7:0] send_byte_q;
	logic       dropped_q, gave_up_q, busy_q;
	logic [3:0] count_q;

	// Next values worked out during execution.
	logic [IDX_W-1:0] wr_idx_d, rd_idx_d, wr_next, rd_next;
	logic [7:0]       cur_byte_d, sent_d;
	logic             cur_valid_d, dropped_d, gave_up_d, active, mem_we;
	logic [1:0]       sends_d;
	logic [ATT_W-1:0] attempt_d, attempt_inc;
	logic [CNT_W-1:0] count_full;
	logic             cfg_we;

	assign wr_next = (wr_idx_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
	assign rd_next = (rd_idx_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_idx_q + 1'b1;
	assign attempt_inc = (attempt_q == ATT_SAT) ? attempt_q : attempt_q + 1'b1;

	// Transaction semantics: enqueue, or one retry step.
	always_comb begin
		wr_idx_d    = wr_idx_q;
		rd_idx_d    = rd_idx_q;
		cur_byte_d  = cur_byte_q;
		cur_valid_d = cur_valid_q;
		attempt_d   = attempt_q;
		sends_d     = 2'd0;
		sent_d      = 8'd0;
		dropped_d   = 1'b0;
		gave_up_d   = 1'b0;
		mem_we      = 1'b0;
		active      = cur_valid_q;
		if (op_q == OP_ENQUEUE) begin
			if (wr_next == rd_idx_q) begin
				dropped_d = 1'b1;
			end else begin
				mem_we   = 1'b1;
				wr_idx_d = wr_next;
			end
		end else begin
			// An idle block loads the next byte; a null byte is consumed unsent.
			if (!cur_valid_q && (rd_idx_q != wr_idx_q)) begin
				rd_idx_d = rd_next;
				if (head_q != null_code_q) begin
					active     = 1'b1;
					cur_byte_d = head_q;
					attempt_d  = ATT_W'(1);
					sends_d    = 2'd1;
					sent_d     = head_q;
				end
			end
			if (active) begin
				case (link_q)
					LINK_SUCCESS: begin
						attempt_d   = '0;
						cur_valid_d = 1'b0;
					end
					LINK_ERROR: begin
						// The count after the raise decides between resend and give up.
						if (cur_valid_q) begin
							attempt_d = attempt_inc;
						end else begin
							attempt_d = ATT_W'(2);
						end
						if (attempt_d > {1'b0, attempt_limit_q}) begin
							attempt_d   = '0;
							cur_valid_d = 1'b0;
							gave_up_d   = 1'b1;
						end else begin
							cur_valid_d = 1'b1;
							sends_d     = sends_d + 2'd1;
							sent_d      = cur_byte_d;
						end
					end
					default: begin
						cur_valid_d = 1'b1;
					end
				endcase
			end
		end
	end

	// Bytes waiting after this transaction.
	always_comb begin
		if (wr_idx_d >= rd_idx_d) begin
			count_full = {1'b0, wr_idx_d} - {1'b0, rd_idx_d};
		end else begin
			count_full = {1'b0, wr_idx_d} + CNT_W'(QUEUE_DEPTH) - {1'b0, rd_idx_d};
		end
	end

	// Queue memory: write on enqueue, read the head when a transaction arrives.
	always_ff @(posedge clk) begin
		if (cmd.execute && mem_we) begin
			mem_q[wr_idx_q] <= msg_q;
		end
		if (cmd.capture) begin
			head_q <= mem_q[rd_idx_q];
		end
	end

	// Transaction latch and result register.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op;
			msg_q  <= message_byte;
			link_q <= link_result;
		end
		if (cmd.execute) begin
			send_count_q <= sends_d;
			send_byte_q  <= sent_d;
			dropped_q    <= dropped_d;
			gave_up_q    <= gave_up_d;
			busy_q       <= cur_valid_d;
			count_q      <= 4'(count_full);
			cur_byte_q   <= cur_byte_d;
		end
	end

	// Queue indexes and retry state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
			cur_valid_q <= 1'b0;
			attempt_q   <= '0;
		end else if (cmd.execute) begin
			wr_idx_q    <= wr_idx_d;
			rd_idx_q    <= rd_idx_d;
			cur_valid_q <= cur_valid_d;
			attempt_q   <= attempt_d;
		end
	end

	// Configuration registers.
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attempt_limit_q <= ATTEMPT_LIMIT_RST;
			null_code_q     <= NULL_CODE_RST;
		end else if (cfg_we) begin
			if (paddr[2] == REG_ATTEMPT_LIMIT) begin
				attempt_limit_q <= pwdata[7:0];
			end else begin
				null_code_q <= pwdata[7:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_NULL_CODE) ? {24'd0, null_code_q}
	                                            : {24'd0, attempt_limit_q};

	assign send_count  = send_count_q;
	assign send_byte   = send_byte_q;
	assign dropped     = dropped_q;
	assign gave_up     = gave_up_q;
	assign busy_res    = busy_q;
	assign queue_count = count_q;

endmodule

// ===== design/retry_queue_sender.sv =====
// ----------------------------------------------------------------------------
// retry_queue_sender: ring queue of failed bytes with a retry engine
// Top level joining the transaction sequencer and the queue datapath.
// ----------------------------------------------------------------------------
// A transaction is accepted in the idle state, which also reads the queue head
// from the ring memory, and applied in the execute state, when its result is
// loaded into the output register. A new transaction can be accepted while
// that result waits to be taken; the apply step stalls only while the output
// register is still full. An enqueue stores a byte or reports a drop when the
// 16-entry queue already holds 15 bytes. A retry step loads the next byte when
// no message is held, then acts on the link result; send_count tells how many
// times send_byte goes out in that step. The two registers (the attempt limit
// at address 0, null_code at address 4) are to be written through the APB port
// only while no transaction is in progress; the block does not enforce this.
module retry_queue_sender
	import rqs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic              op,
	input  logic [7:0]        message_byte,
	input  logic [1:0]        link_result,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [1:0]        send_count,
	output logic [7:0]        send_byte,
	output logic              dropped,
	output logic              gave_up,
	output logic              busy_res,
	output logic [3:0]        queue_count,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	ctrl_cmd_t cmd;

	assign pready = 1'b1;

	// Transaction sequencer.
	rqs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.cmd        (cmd)
	);

	// Queue, retry state and configuration.
	rqs_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.op           (op),
		.message_byte (message_byte),
		.link_result  (link_result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.send_count   (send_count),
		.send_byte    (send_byte),
		.dropped      (dropped),
		.gave_up      (gave_up),
		.busy_res     (busy_res),
		.queue_count  (queue_count)
	);

	// A dropped enqueue never sends anything and never abandons a message.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && dropped |-> send_count == 2'd0 && !gave_up)
		else $error("dropped transaction carries a send or give-up");

	// An abandoned message is no longer held.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && gave_up |-> !busy_res)
		else $error("message still held after give-up");

	// An accepted transaction keeps the input closed for the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("input reopened while a transaction is at work");

	// Nothing is reported as sent when the send count is zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && send_count == 2'd0 |-> send_byte == 8'd0)
		else $error("send byte set without a send");

endmodule
